FILE: sv/ggt_pkg.sv
// Shared types and constants of the generational grant table.
package ggt_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int HEAD_W     = 9;
  localparam int SEQ_W      = 11;
  localparam int HANDLE_W   = 19;
  localparam int FAULT_W    = 20;

  // Input modes
  localparam logic [2:0] MODE_DIRECT   = 3'd0;
  localparam logic [2:0] MODE_INDIRECT = 3'd1;
  localparam logic [2:0] MODE_MAGIC    = 3'd2;
  localparam logic [2:0] MODE_REVOKE   = 3'd3;
  localparam logic [2:0] MODE_FAULT    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_FAULTED = 2'd3;

  // Classified operations handed from front to back
  localparam logic [1:0] OP_GRANT  = 2'd0;
  localparam logic [1:0] OP_REVOKE = 2'd1;
  localparam logic [1:0] OP_FAULT  = 2'd2;
  localparam logic [1:0] OP_REJECT = 2'd3;

  // Fault entry with the top bit set: no fault noted
  localparam logic [FAULT_W-1:0] FAULT_NONE = {1'b1, {(FAULT_W-1){1'b0}}};
  localparam logic [HEAD_W-1:0]  HEAD_EMPTY = HEAD_W'(TABLE_SIZE);

  typedef struct packed {
    logic [1:0]          op;
    logic                try_bit;
    logic [HANDLE_W-1:0] handle;
  } ggt_entry_t;

  typedef struct packed {
    logic                try_bit;
    logic                used;
    logic [SEQ_W-1:0]    seq;
    logic [HEAD_W-1:0]   next_free;
    logic [FAULT_W-1:0]  fault;
  } ggt_slot_t;

  localparam int SLOT_W = $bits(ggt_slot_t);

endpackage

FILE: sv/ggt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ggt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/ggt_front.sv
// Front end: takes items and classifies them into operations.
module ggt_front
  import ggt_pkg::*;
(
  input  logic                start,
  input  logic                q_full,
  input  logic [2:0]          in_mode,
  input  logic [7:0]          in_access_bits,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                busy,
  output logic                push,
  output ggt_entry_t          entry
);

  logic bad_acc;

  assign busy    = q_full;
  assign push    = start && !q_full;
  assign bad_acc = |in_access_bits[7:3];

  // Classify mode and access bits
  always_comb begin
    entry.handle  = in_handle;
    entry.try_bit = 1'b0;
    entry.op      = OP_REJECT;
    unique case (in_mode) inside
      MODE_DIRECT, MODE_MAGIC: begin
        entry.op      = bad_acc ? OP_REJECT : OP_GRANT;
        entry.try_bit = in_access_bits[2];
      end
      MODE_INDIRECT: entry.op = OP_GRANT;
      MODE_REVOKE:   entry.op = OP_REVOKE;
      MODE_FAULT:    entry.op = OP_FAULT;
      default:       entry.op = OP_REJECT;
    endcase
  end

endmodule

FILE: sv/ggt_queue.sv
// Two-entry queue between front end and back end.
module ggt_queue
  import ggt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ggt_entry_t push_entry,
  input  logic       pop,
  output ggt_entry_t pop_entry,
  output logic       full,
  output logic       empty
);

  ggt_entry_t  buf_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign pop_entry = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/ggt_back.sv
// Back end: reads the slot record, updates it and the free list, issues the result.
module ggt_back
  import ggt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ggt_entry_t          q_entry,
  output logic                q_pop,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_new_handle
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  ggt_entry_t            op_r;
  logic [IDX_W-1:0]      addr_r, rd_addr;
  logic [HEAD_W-1:0]     head_r, head_nxt;
  logic [TABLE_SIZE-1:0] vld_r;
  logic [SLOT_W-1:0]     rd_data;
  ggt_slot_t             rec, wr_rec;
  logic                  wr_en;
  logic [1:0]            status;
  logic [HANDLE_W-1:0]   nh;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [HANDLE_W-1:0]   out_nh_r;

  assign q_pop          = (state_r == S_IDLE) && !q_empty;
  assign rd_addr        = (q_entry.op == OP_GRANT) ? head_r[IDX_W-1:0]
                                                   : q_entry.handle[IDX_W-1:0];
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_handle = out_nh_r;

  ggt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SIZE)) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_rec),
    .rd_en   (q_pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slot never written reads as its reset record
  always_comb begin
    if (vld_r[addr_r]) begin
      rec = ggt_slot_t'(rd_data);
    end else begin
      rec.try_bit   = 1'b0;
      rec.used      = 1'b0;
      rec.seq       = '0;
      rec.next_free = HEAD_W'(addr_r) + HEAD_W'(1);
      rec.fault     = FAULT_NONE;
    end
  end

  // Execute the operation
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    wr_en     = 1'b0;
    wr_rec    = rec;
    status    = ST_OK;
    nh        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (op_r.op)
          OP_GRANT: begin
            if (head_r == HEAD_EMPTY) begin
              status = ST_NOSPACE;
            end else begin
              wr_en          = 1'b1;
              wr_rec.used    = 1'b1;
              wr_rec.try_bit = op_r.try_bit;
              wr_rec.fault   = FAULT_NONE;
              head_nxt       = rec.next_free;
              nh             = {rec.seq, addr_r};
            end
          end
          OP_REVOKE: begin
            if (rec.seq != op_r.handle[HANDLE_W-1:IDX_W] || !rec.used) begin
              status = ST_INVAL;
            end else begin
              status = (rec.try_bit && rec.fault == {1'b0, op_r.handle})
                       ? ST_FAULTED : ST_OK;
              wr_en            = 1'b1;
              wr_rec.used      = 1'b0;
              wr_rec.try_bit   = 1'b0;
              wr_rec.seq       = rec.seq + SEQ_W'(1);
              wr_rec.next_free = head_r;
              head_nxt         = HEAD_W'(addr_r);
            end
          end
          OP_FAULT: begin
            wr_en        = 1'b1;
            wr_rec.fault = {1'b0, op_r.handle};
          end
          default: status = ST_INVAL;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= (state_r == S_EXEC);
      if (wr_en) vld_r[addr_r] <= 1'b1;
    end
  end

  // Operation and result registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r   <= q_entry;
      addr_r <= rd_addr;
    end
    out_status_r <= status;
    out_nh_r     <= nh;
  end

endmodule

FILE: sv/generational_grant_table.sv
// Grant table top level. Up to three items can be held at once: two in the queue and one in the
// back end. An accepted item waits in the queue until the back end is idle and then is popped.
// The slot RAM is read as the item is popped, and the slot is updated and written in the
// back end's execute state. The result is then held for one cycle under a single-cycle out_valid
// strobe that cannot be stalled. The back end cannot take a new item before it is through with
// the last one, since it reads and then writes the one slot RAM for each item. start is refused
// (busy) only while the two-entry queue is full. There is no clearing pass after reset.
module generational_grant_table
  import ggt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_mode,
  input  logic signed [31:0]  in_target_endpoint,
  input  logic signed [31:0]  in_source_endpoint,
  input  logic [31:0]         in_start_address,
  input  logic [31:0]         in_byte_length,
  input  logic [7:0]          in_access_bits,
  input  logic [HANDLE_W-1:0] in_handle,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_new_handle
);

  ggt_entry_t push_entry, pop_entry;
  logic       push, pop, q_full, q_empty;

  ggt_front u_front (
    .start          (start),
    .q_full         (q_full),
    .in_mode        (in_mode),
    .in_access_bits (in_access_bits),
    .in_handle      (in_handle),
    .busy           (busy),
    .push           (push),
    .entry          (push_entry)
  );

  ggt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  ggt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_new_handle (out_new_handle)
  );

endmodule

FILE: sv/ggt_checker.sv
// Port-level checks of the grant table, bound to the top level.
module ggt_checker
  import ggt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [1:0]          out_status,
  input logic [HANDLE_W-1:0] out_new_handle
);

  // The back end passes through idle between items, so no two results come back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results on consecutive cycles");

  // Only a successful grant carries a handle
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_new_handle == '0)
    else $error("handle on failed operation");

  // Nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  // A result needs an item taken before it, through the queue and the back end's execute state
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 3)) |-> ($past(start && !busy, 3) ||
      $past(start && !busy, 4) || $past(start && !busy, 5) ||
      $past(start && !busy, 6) || !$past(rst_n, 6)))
    else $error("result without item");

endmodule

bind generational_grant_table ggt_checker u_ggt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_new_handle (out_new_handle)
);
